/* src/faq_pkg.sv */
// ----------------------------------------------------------------------------
// faq_pkg
// shared types, codes and defaults of the q24.8 fixed-point alu
// ----------------------------------------------------------------------------
package faq_pkg;

  // default number of fraction bits
  localparam int FRAC_BITS_DEF = 8;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP_BITS = 4;

  typedef enum logic [4:0] {
    CMD_ADD        = 5'd0,
    CMD_SUB        = 5'd1,
    CMD_MUL        = 5'd2,
    CMD_DIV        = 5'd3,
    CMD_GT         = 5'd4,
    CMD_LT         = 5'd5,
    CMD_GE         = 5'd6,
    CMD_LE         = 5'd7,
    CMD_EQ         = 5'd8,
    CMD_NE         = 5'd9,
    CMD_MIN        = 5'd10,
    CMD_MAX        = 5'd11,
    CMD_INC        = 5'd12,
    CMD_DEC        = 5'd13,
    CMD_FROM_INT   = 5'd14,
    CMD_FROM_FLOAT = 5'd15,
    CMD_TO_INT     = 5'd16,
    CMD_TO_FLOAT   = 5'd17
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  // result of the float to fixed unit
  typedef struct packed {
    logic [31:0] res;
    logic        sat;
  } ff_res_t;

endpackage

/* src/fixed_point_q24_8_alu_top.sv */
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top
// pipelined signed fixed-point alu with fraction bit count FRAC_BITS
// ----------------------------------------------------------------------------
// usage
//   a request on the in_ channel carries a command and two operands; one
//   result per request leaves on the out_ channel in request order
//   every command takes the same path length from acceptance to
//   out_valid; the divider pipeline, four quotient bits per stage,
//   sets that length
//   throughput is one request per cycle for any command mix while
//   out_stall does not hold a waiting result
//   reset clears all valid bits; no result is pending afterwards
//   when out_stall holds a waiting result the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top
  import faq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [4:0]  in_command,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result,
  output logic               out_compare_flag,
  output logic        [1:0]  out_status
);

  localparam int NDIV = (32 + FRAC_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int LAT  = NDIV + 2;

  logic               en;
  logic               v0_r;
  cmd_t               cmd0_r;
  logic signed [31:0] a0_r;
  logic signed [31:0] b0_r;
  logic               vl_r [1:LAT];
  logic [32:0]        simple_nxt;
  logic [32:0]        simple_r;
  logic [32:0]        simple_l;
  logic [31:0]        mul_res, mul_l;
  logic [31:0]        div_res;
  logic               div0;
  ff_res_t            ff_res, ff_l;
  logic [31:0]        tf_res, tf_l;
  logic [4:0]         cmd_l;
  logic               out_valid_r;
  logic [31:0]        out_result_r;
  logic               out_flag_r;
  logic [1:0]         out_status_r;
  logic               gt;

  // global advance
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd0_r <= cmd_t'(in_command);
      a0_r   <= in_operand_a;
      b0_r   <= in_operand_b;
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= LAT; i++) vl_r[i] <= 1'b0;
    end else if (en) begin
      vl_r[1] <= v0_r;
      for (int i = 2; i <= LAT; i++) vl_r[i] <= vl_r[i-1];
    end
  end

  // simple commands: result and flag
  assign gt = (a0_r > b0_r);

  always_comb begin
    simple_nxt = '0;
    case (cmd0_r)
      CMD_ADD:      simple_nxt[31:0] = a0_r + b0_r;
      CMD_SUB:      simple_nxt[31:0] = a0_r - b0_r;
      CMD_GT:       simple_nxt[32] = gt;
      CMD_LT:       simple_nxt[32] = (a0_r < b0_r);
      CMD_GE:       simple_nxt[32] = (a0_r >= b0_r);
      CMD_LE:       simple_nxt[32] = (a0_r <= b0_r);
      CMD_EQ:       simple_nxt[32] = (a0_r == b0_r);
      CMD_NE:       simple_nxt[32] = (a0_r != b0_r);
      CMD_MIN:      simple_nxt[31:0] = gt ? b0_r : a0_r;
      CMD_MAX:      simple_nxt[31:0] = gt ? a0_r : b0_r;
      CMD_INC:      simple_nxt[31:0] = a0_r + 32'sd1;
      CMD_DEC:      simple_nxt[31:0] = a0_r - 32'sd1;
      CMD_FROM_INT: simple_nxt[31:0] = a0_r << FRAC_BITS;
      CMD_TO_INT:   simple_nxt[31:0] = a0_r >>> FRAC_BITS;
      default:      simple_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      simple_r <= simple_nxt;
    end
  end

  // arithmetic units
  faq_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .en(en), .a(a0_r), .b(b0_r), .res(mul_res)
  );

  faq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .en(en), .a(a0_r), .b(b0_r), .res(div_res), .div0(div0)
  );

  faq_f2x #(.FRAC_BITS(FRAC_BITS)) u_f2x (
    .clk(clk), .en(en), .bits_in(a0_r), .res(ff_res)
  );

  faq_x2f #(.FRAC_BITS(FRAC_BITS)) u_x2f (
    .clk(clk), .en(en), .a(a0_r), .res(tf_res)
  );

  // alignment to the divider latency
  faq_delay #(.WIDTH(5), .DEPTH(LAT)) u_dly_cmd (
    .clk(clk), .en(en), .d(cmd0_r), .q(cmd_l)
  );

  faq_delay #(.WIDTH(33), .DEPTH(LAT - 1)) u_dly_simple (
    .clk(clk), .en(en), .d(simple_r), .q(simple_l)
  );

  faq_delay #(.WIDTH(32), .DEPTH(LAT - 2)) u_dly_mul (
    .clk(clk), .en(en), .d(mul_res), .q(mul_l)
  );

  faq_delay #(.WIDTH(33), .DEPTH(LAT - 3)) u_dly_ff (
    .clk(clk), .en(en), .d(ff_res), .q(ff_l)
  );

  faq_delay #(.WIDTH(32), .DEPTH(LAT - 4)) u_dly_tf (
    .clk(clk), .en(en), .d(tf_res), .q(tf_l)
  );

  // result select into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vl_r[LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (cmd_t'(cmd_l))
        CMD_MUL: begin
          out_result_r <= mul_l;
          out_flag_r   <= 1'b0;
          out_status_r <= ST_OK;
        end
        CMD_DIV: begin
          out_result_r <= div_res;
          out_flag_r   <= 1'b0;
          out_status_r <= div0 ? ST_DIV0 : ST_OK;
        end
        CMD_FROM_FLOAT: begin
          out_result_r <= ff_l.res;
          out_flag_r   <= 1'b0;
          out_status_r <= ff_l.sat ? ST_SAT : ST_OK;
        end
        CMD_TO_FLOAT: begin
          out_result_r <= tf_l;
          out_flag_r   <= 1'b0;
          out_status_r <= ST_OK;
        end
        default: begin
          out_result_r <= simple_l[31:0];
          out_flag_r   <= simple_l[32];
          out_status_r <= ST_OK;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result       = out_result_r;
  assign out_compare_flag = out_flag_r;
  assign out_status       = out_status_r;

endmodule

/* src/faq_delay.sv */
// ----------------------------------------------------------------------------
// faq_delay
// enabled shift line that aligns a unit result with the pipeline end
// ----------------------------------------------------------------------------
module faq_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [0:DEPTH-1];

  // shift on every advance of the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

/* src/faq_mul.sv */
// ----------------------------------------------------------------------------
// faq_mul
// two-stage rounded fixed-point multiply
// ----------------------------------------------------------------------------
module faq_mul
  import faq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic        [31:0] res
);

  logic signed [63:0] prod_r;
  logic        [31:0] res_r;

  // full product, then scale with half-up rounding
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
      res_r  <= 32'(prod_r >>> FRAC_BITS) + {31'd0, prod_r[FRAC_BITS-1]};
    end
  end

  assign res = res_r;

endmodule

/* src/faq_div.sv */
// ----------------------------------------------------------------------------
// faq_div
// pipelined restoring divider, DIV_STEP_BITS quotient bits per stage
// ----------------------------------------------------------------------------
module faq_div
  import faq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic        [31:0] res,
  output logic               div0
);

  localparam int DW   = 32 + FRAC_BITS;
  localparam int NDIV = (DW + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int NW   = NDIV * DIV_STEP_BITS;

  logic [NW-1:0] num_r  [0:NDIV];
  logic [31:0]   rem_r  [0:NDIV];
  logic [31:0]   den_r  [0:NDIV];
  logic          neg_r  [0:NDIV];
  logic          zero_r [0:NDIV];
  logic [31:0]   res_r;
  logic          div0_r;
  logic [31:0]   amag;
  logic [31:0]   bmag;
  logic [31:0]   q;

  assign amag = a[31] ? 32'(-a) : a;
  assign bmag = b[31] ? 32'(-b) : b;

  // operand magnitudes and scaled dividend
  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0]  <= NW'({amag, {FRAC_BITS{1'b0}}});
      rem_r[0]  <= '0;
      den_r[0]  <= bmag;
      neg_r[0]  <= a[31] ^ b[31];
      zero_r[0] <= (b == '0);
    end
  end

  // division steps
  for (genvar s = 0; s < NDIV; s++) begin : g_step
    logic [NW-1:0] num_nxt;
    logic [31:0]   rem_nxt;

    always_comb begin
      logic [32:0]   t;
      logic [31:0]   r;
      logic [NW-1:0] n;
      r = rem_r[s];
      n = num_r[s];
      for (int k = 0; k < DIV_STEP_BITS; k++) begin
        t = {r, n[NW-1]};
        n = {n[NW-2:0], 1'b0};
        if (t >= {1'b0, den_r[s]}) begin
          t    = t - {1'b0, den_r[s]};
          n[0] = 1'b1;
        end
        r = t[31:0];
      end
      num_nxt = n;
      rem_nxt = r;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[s+1]  <= num_nxt;
        rem_r[s+1]  <= rem_nxt;
        den_r[s+1]  <= den_r[s];
        neg_r[s+1]  <= neg_r[s];
        zero_r[s+1] <= zero_r[s];
      end
    end
  end

  // sign of the quotient and divide by zero
  assign q = num_r[NDIV][31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= zero_r[NDIV] ? '0 : (neg_r[NDIV] ? 32'(-q) : q);
      div0_r <= zero_r[NDIV];
    end
  end

  assign res  = res_r;
  assign div0 = div0_r;

endmodule

/* src/faq_f2x.sv */
// ----------------------------------------------------------------------------
// faq_f2x
// three-stage ieee single to fixed conversion with saturation
// ----------------------------------------------------------------------------
module faq_f2x
  import faq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] bits_in,
  output ff_res_t     res
);

  // stage 1
  logic              neg1_r;
  logic              spec1_r;
  logic              nan1_r;
  logic [23:0]       man1_r;
  logic signed [9:0] sh1_r;
  // stage 2
  logic              neg2_r;
  logic              spec2_r;
  logic              nan2_r;
  logic [55:0]       mag2_r;
  // stage 3
  ff_res_t           res_r;

  logic [7:0]        ex;
  logic [55:0]       mag_nxt;
  logic [4:0]        n;

  assign ex = bits_in[30:23];

  // field decode and shift amount
  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= bits_in[31];
      spec1_r <= (ex == 8'hFF);
      nan1_r  <= (bits_in[22:0] != '0);
      if (ex == '0) begin
        man1_r <= {1'b0, bits_in[22:0]};
        sh1_r  <= -10'sd149 + 10'(FRAC_BITS);
      end else begin
        man1_r <= {1'b1, bits_in[22:0]};
        sh1_r  <= $signed({2'b00, ex}) - 10'sd150 + 10'(FRAC_BITS);
      end
    end
  end

  // scale with half away from zero rounding
  assign n = 5'(-sh1_r);

  always_comb begin
    if (sh1_r > 10'sd31) begin
      mag_nxt = 56'd1 << 40;
    end else if (sh1_r >= 10'sd0) begin
      mag_nxt = 56'(man1_r) << sh1_r[4:0];
    end else if (sh1_r <= -10'sd25) begin
      mag_nxt = '0;
    end else begin
      mag_nxt = (56'(man1_r) + (56'd1 << (n - 5'd1))) >> n;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2_r  <= neg1_r;
      spec2_r <= spec1_r;
      nan2_r  <= nan1_r;
      mag2_r  <= mag_nxt;
    end
  end

  // saturation and sign
  always_ff @(posedge clk) begin
    if (en) begin
      if (spec2_r) begin
        res_r.sat <= 1'b1;
        res_r.res <= nan2_r ? '0 : (neg2_r ? 32'h8000_0000 : 32'h7FFF_FFFF);
      end else if (!neg2_r) begin
        res_r.sat <= (mag2_r > 56'h7FFF_FFFF);
        res_r.res <= (mag2_r > 56'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag2_r[31:0];
      end else begin
        res_r.sat <= (mag2_r > 56'h8000_0000);
        res_r.res <= (mag2_r > 56'h8000_0000) ? 32'h8000_0000 : 32'(-mag2_r[31:0]);
      end
    end
  end

  assign res = res_r;

endmodule

/* src/faq_x2f.sv */
// ----------------------------------------------------------------------------
// faq_x2f
// four-stage fixed to ieee single conversion, round to nearest even
// ----------------------------------------------------------------------------
module faq_x2f
  import faq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  output logic        [31:0] res
);

  logic        sign1_r, sign2_r, sign3_r;
  logic        zero1_r, zero2_r, zero3_r;
  logic [31:0] mag1_r, mag2_r;
  logic [4:0]  p2_r, p3_r;
  logic [31:0] norm3_r;
  logic [31:0] res_r;
  logic [4:0]  p_nxt;
  logic        rnd;
  logic [24:0] keep;
  logic [5:0]  pe;
  logic [7:0]  ex;

  // sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      sign1_r <= a[31];
      zero1_r <= (a == '0);
      mag1_r  <= a[31] ? 32'(-a) : a;
    end
  end

  // leading one position
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag1_r[i]) p_nxt = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sign2_r <= sign1_r;
      zero2_r <= zero1_r;
      mag2_r  <= mag1_r;
      p2_r    <= p_nxt;
    end
  end

  // normalize with the leading one at the top
  always_ff @(posedge clk) begin
    if (en) begin
      sign3_r <= sign2_r;
      zero3_r <= zero2_r;
      p3_r    <= p2_r;
      norm3_r <= mag2_r << (5'd31 - p2_r);
    end
  end

  // round, renormalize on carry, pack
  assign rnd  = norm3_r[7] && ((norm3_r[6:0] != '0) || norm3_r[8]);
  assign keep = {1'b0, norm3_r[31:8]} + {24'd0, rnd};
  assign pe   = {1'b0, p3_r} + {5'd0, keep[24]};
  assign ex   = 8'(pe) - 8'(FRAC_BITS) + 8'd127;

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero3_r) begin
        res_r <= '0;
      end else begin
        res_r <= {sign3_r, ex, keep[24] ? keep[23:1] : keep[22:0]};
      end
    end
  end

  assign res = res_r;

endmodule
